/* hdl/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, operand and store codes, controller states and the
// command / status bundles of the segment sphere crossing block.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int TIME_W    = 48;
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int DATA_W    = TIME_W + 6 * COORD_W;   // 240, whole bytes
  localparam int OPD_W     = 67;                     // multiply operand width
  localparam int ACC_W     = 2 * OPD_W;              // product / accumulator width
  localparam int NB_W      = 7;                      // operand bit count field
  localparam int N_W       = 65;                     // squared norms, signed
  localparam int A_W       = 67;                     // d.d, signed holder
  localparam int H_W       = 66;                     // r1.d and c
  localparam int DISC_W    = 128;
  localparam int SQ_W      = DISC_W / 2;
  localparam int NUM_W     = A_W + 1;                // root numerators
  localparam int DEN_W     = A_W - 1;
  localparam int ROOT_FRAC = 32;
  localparam int Q_W       = ROOT_FRAC + 1;
  localparam int POS_SHIFT = 28;
  localparam int E_W       = TIME_W + 2;
  localparam int EV_W      = E_W + COORD_W;          // e times velocity
  localparam int PS_W      = EV_W - POS_SHIFT + 1;   // shifted product plus position
  localparam int STEP_W    = 4;
  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(417529856);

  // operand bit counts for the multiply-accumulate unit
  localparam logic [NB_W-1:0] NB_COORD = NB_W'(COORD_W);
  localparam logic [NB_W-1:0] NB_DIFF  = NB_W'(COORD_W + 1);
  localparam logic [NB_W-1:0] NB_WIDE  = NB_W'(H_W);
  localparam logic [NB_W-1:0] NB_FRAC  = NB_W'(Q_W + 1);

  localparam logic [STEP_W-1:0] STEP_A    = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_H    = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(14);

  typedef enum logic [2:0] {
    A_P1, A_P2, A_D, A_RAD, A_H, A_NEGA, A_DT, A_E
  } asel_t;

  typedef enum logic [2:0] {
    B_P1, B_P2, B_D, B_RAD, B_H, B_C, B_L, B_V1
  } bsel_t;

  typedef enum logic [3:0] {
    SD_NONE, SD_N1, SD_N2, SD_RR, SD_A, SD_H, SD_DISC, SD_E, SD_POS
  } store_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEG_GO, S_SEG_WAIT, S_SQRT_GO, S_SQRT_WAIT, S_ROOT_SEL,
    S_DIV_GO, S_DIV_WAIT, S_E_GO, S_E_WAIT, S_V_GO, S_V_WAIT, S_EMIT, S_COMMIT
  } state_t;

  typedef struct packed {
    asel_t             asel;
    bsel_t             bsel;
    logic [1:0]        comp;
    logic [NB_W-1:0]   nbits;
    logic              clear;
    store_t            store;
  } mop_t;

  typedef struct packed {
    logic       capture;
    logic       commit;
    logic       mac_start;
    mop_t       op;
    store_t     store;
    logic       sqrt_start;
    logic       div_start;
    logic       root_plus;
    logic       out_load;
    logic       out_last;
  } ssc_cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic sqrt_busy;
    logic div_busy;
    logic out_busy;
    logic in1;
    logic in2;
    logic out1;
    logic out2;
    logic a_zero;
    logic disc_neg;
    logic disc_zero;
    logic m_ok;
    logic p_ok;
  } ssc_sts_t;

endpackage

/* hdl/ssc_mac.sv */
// ----------------------------------------------------------------------------
// ssc_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ssc_mac import ssc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    clear,
  input  logic signed [OPD_W-1:0] mcand,
  input  logic signed [OPD_W-1:0] mplier,
  input  logic [NB_W-1:0]         nbits,
  output logic                    busy,
  output logic signed [ACC_W-1:0] acc
);

  logic                    busy_r;
  logic signed [ACC_W-1:0] acc_r, mc_r, addend;
  logic        [OPD_W-1:0] mp_r;
  logic [NB_W-1:0]         cnt_r, nb_r;
  logic                    last_bit;

  assign addend   = mp_r[0] ? mc_r : '0;
  assign last_bit = (cnt_r == NB_W'(nb_r - 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && last_bit) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= ACC_W'(mcand);
      mp_r  <= mplier;
      nb_r  <= nbits;
      cnt_r <= '0;
      if (clear) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      // sign bit of the multiplier carries negative weight
      if (last_bit) begin
        acc_r <= acc_r - addend;
      end else begin
        acc_r <= acc_r + addend;
      end
      mc_r  <= mc_r <<< 1;
      mp_r  <= mp_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign acc  = acc_r;

endmodule

/* hdl/ssc_sqrt.sv */
// ----------------------------------------------------------------------------
// ssc_sqrt
// Floor integer square root, restoring, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ssc_sqrt import ssc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DISC_W-1:0] radicand,
  output logic              busy,
  output logic [SQ_W-1:0]   root
);

  localparam int REM_W = SQ_W + 4;
  localparam int CNT_W = $clog2(SQ_W);

  logic              busy_r;
  logic [DISC_W-1:0] rad_r;
  logic [REM_W-1:0]  rem_r, rem_sh, trial;
  logic [SQ_W-1:0]   root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              fits;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[DISC_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == CNT_W'(SQ_W - 1))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[SQ_W-2:0], fits};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

/* hdl/ssc_div.sv */
// ----------------------------------------------------------------------------
// ssc_div
// Root fraction num * 2^32 / den for num <= den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ssc_div import ssc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEN_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(Q_W);

  logic             busy_r;
  logic [DEN_W:0]   rem_r, rem_a;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ge;

  assign ge    = (rem_r >= {1'b0, den_r});
  assign rem_a = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == CNT_W'(Q_W - 1))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_a[DEN_W-1:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

/* hdl/ssc_datapath.sv */
// ----------------------------------------------------------------------------
// ssc_datapath
// Event registers, quadratic terms, shared arithmetic units and result register.
// ----------------------------------------------------------------------------
module ssc_datapath import ssc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DATA_W-1:0]  in_tdata,
  input  logic               cfg_wr_en,
  input  logic [RAD_W-1:0]   cfg_wr_data,
  input  ssc_cmd_t           cmd,
  output ssc_sts_t           sts,
  output logic [DATA_W-1:0]  out_tdata,
  output logic               out_tlast,
  output logic               out_tvalid,
  input  logic               out_tready
);

  logic [RAD_W-1:0]          radius_r;
  logic [TIME_W-1:0]         prev_time_r, cur_time_r;
  logic signed [COORD_W-1:0] prev_pos_r [3];
  logic signed [COORD_W-1:0] prev_vel_r [3];
  logic signed [COORD_W-1:0] cur_pos_r  [3];
  logic signed [COORD_W-1:0] cur_vel_r  [3];
  logic signed [COORD_W:0]   d_r        [3];
  logic signed [COORD_W-1:0] res_pos_r  [3];
  logic signed [N_W-1:0]     n1_r, n2_r, rr_r;
  logic signed [A_W-1:0]     a_r;
  logic signed [H_W-1:0]     h_r;
  logic [DISC_W-1:0]         disc_r;
  logic                      disc_neg_r;
  logic signed [E_W-1:0]     e_r;

  logic                      out_valid_r, out_last_r;
  logic [TIME_W-1:0]         out_time_r;
  logic signed [COORD_W-1:0] out_pos_r [3];
  logic signed [COORD_W-1:0] out_vel_r [3];

  logic signed [COORD_W-1:0] in_pos [3];
  logic signed [COORD_W-1:0] in_vel [3];
  logic signed [TIME_W:0]    dt;
  logic signed [H_W-1:0]     c_term;
  logic signed [A_W-1:0]     nh;
  logic signed [NUM_W-1:0]   num_m, num_p;
  logic signed [OPD_W-1:0]   op_a, op_b;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PS_W-1:0]    psum;
  logic signed [COORD_W-1:0] psat;
  logic [SQ_W-1:0]           s_root;
  logic [Q_W-1:0]            quot;
  logic                      mac_busy, sqrt_busy, div_busy;

  localparam logic signed [PS_W-1:0] CMAX = PS_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [PS_W-1:0] CMIN = -CMAX - PS_W'(1);

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign in_pos[i] = in_tdata[TIME_W + COORD_W*i +: COORD_W];
    assign in_vel[i] = in_tdata[TIME_W + COORD_W*(i+3) +: COORD_W];
  end

  assign dt     = $signed({1'b0, cur_time_r}) - $signed({1'b0, prev_time_r});
  assign c_term = H_W'(n1_r) - H_W'(rr_r);
  assign nh     = -(A_W'(h_r));
  assign num_m  = NUM_W'(nh) - $signed({{(NUM_W-SQ_W){1'b0}}, s_root});
  assign num_p  = NUM_W'(nh) + $signed({{(NUM_W-SQ_W){1'b0}}, s_root});

  // operand selection for the shared multiply-accumulate unit
  always_comb begin
    case (cmd.op.asel)
      A_P1:    op_a = OPD_W'(prev_pos_r[cmd.op.comp]);
      A_P2:    op_a = OPD_W'(cur_pos_r[cmd.op.comp]);
      A_D:     op_a = OPD_W'(d_r[cmd.op.comp]);
      A_RAD:   op_a = $signed({{(OPD_W-RAD_W){1'b0}}, radius_r});
      A_H:     op_a = OPD_W'(h_r);
      A_NEGA:  op_a = -a_r;
      A_DT:    op_a = OPD_W'(dt);
      A_E:     op_a = OPD_W'(e_r);
      default: op_a = '0;
    endcase
    case (cmd.op.bsel)
      B_P1:    op_b = OPD_W'(prev_pos_r[cmd.op.comp]);
      B_P2:    op_b = OPD_W'(cur_pos_r[cmd.op.comp]);
      B_D:     op_b = OPD_W'(d_r[cmd.op.comp]);
      B_RAD:   op_b = $signed({{(OPD_W-RAD_W){1'b0}}, radius_r});
      B_H:     op_b = OPD_W'(h_r);
      B_C:     op_b = OPD_W'(c_term);
      B_L:     op_b = $signed({{(OPD_W-Q_W){1'b0}}, quot});
      B_V1:    op_b = OPD_W'(prev_vel_r[cmd.op.comp]);
      default: op_b = '0;
    endcase
  end

  ssc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mac_start),
    .clear  (cmd.op.clear),
    .mcand  (op_a),
    .mplier (op_b),
    .nbits  (cmd.op.nbits),
    .busy   (mac_busy),
    .acc    (acc)
  );

  ssc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (disc_r),
    .busy     (sqrt_busy),
    .root     (s_root)
  );

  ssc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.root_plus ? num_p[DEN_W-1:0] : num_m[DEN_W-1:0]),
    .den   (a_r[DEN_W-1:0]),
    .busy  (div_busy),
    .quot  (quot)
  );

  // start position plus floor(e * v / 2^28), saturated
  assign psum = PS_W'(prev_pos_r[cmd.op.comp]) + PS_W'($signed(acc[EV_W-1:POS_SHIFT]));
  always_comb begin
    if (psum > CMAX) begin
      psat = COORD_W'(CMAX);
    end else if (psum < CMIN) begin
      psat = COORD_W'(CMIN);
    end else begin
      psat = psum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // previous event, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_pos_r[i] <= '0;
        prev_vel_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      prev_time_r <= cur_time_r;
      for (int i = 0; i < 3; i++) begin
        prev_pos_r[i] <= cur_pos_r[i];
        prev_vel_r[i] <= cur_vel_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_time_r <= in_tdata[TIME_W-1:0];
      for (int i = 0; i < 3; i++) begin
        cur_pos_r[i] <= in_pos[i];
        cur_vel_r[i] <= in_vel[i];
        d_r[i]       <= (COORD_W+1)'(in_pos[i]) - (COORD_W+1)'(prev_pos_r[i]);
      end
    end
    case (cmd.store)
      SD_N1:   n1_r <= acc[N_W-1:0];
      SD_N2:   n2_r <= acc[N_W-1:0];
      SD_RR:   rr_r <= acc[N_W-1:0];
      SD_A:    a_r  <= acc[A_W-1:0];
      SD_H:    h_r  <= acc[H_W-1:0];
      SD_DISC: begin
        disc_r     <= acc[DISC_W-1:0];
        disc_neg_r <= acc[ACC_W-1];
      end
      SD_E:    e_r  <= acc[ROOT_FRAC +: E_W];
      SD_POS:  res_pos_r[cmd.op.comp] <= psat;
      default: ;
    endcase
  end

  // result register, parts the result side from the item side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_time_r <= prev_time_r + e_r[TIME_W-1:0];
      out_last_r <= cmd.out_last;
      for (int i = 0; i < 3; i++) begin
        out_pos_r[i] <= res_pos_r[i];
        out_vel_r[i] <= prev_vel_r[i];
      end
    end
  end

  assign out_tdata  = {out_vel_r[2], out_vel_r[1], out_vel_r[0],
                       out_pos_r[2], out_pos_r[1], out_pos_r[0], out_time_r};
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  always_comb begin
    sts.mac_busy  = mac_busy;
    sts.sqrt_busy = sqrt_busy;
    sts.div_busy  = div_busy;
    sts.out_busy  = out_valid_r && !out_tready;
    sts.in1       = (n1_r < rr_r);
    sts.in2       = (n2_r < rr_r);
    sts.out1      = (n1_r > rr_r);
    sts.out2      = (n2_r > rr_r);
    sts.a_zero    = (a_r == '0);
    sts.disc_neg  = disc_neg_r;
    sts.disc_zero = (disc_r == '0);
    sts.m_ok      = !num_m[NUM_W-1] && (num_m <= NUM_W'(a_r));
    sts.p_ok      = !num_p[NUM_W-1] && (num_p <= NUM_W'(a_r));
  end

endmodule

/* hdl/ssc_ctrl.sv */
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer: event counting, arithmetic step order, root selection, emit.
// ----------------------------------------------------------------------------
module ssc_ctrl import ssc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_first,
  input  logic     in_last,
  output logic     in_tready,
  input  ssc_sts_t sts,
  output ssc_cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        vcomp_r, vcomp_nxt;
  logic              root_idx_r, root_idx_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              examine, skip, two_roots, cur_plus, cur_ok, next_ok;
  mop_t              sop;

  function automatic mop_t seg_step(input logic [STEP_W-1:0] s);
    mop_t m;
    m       = '0;
    m.store = SD_NONE;
    case (s)
      4'd0, 4'd1, 4'd2: begin
        m.asel = A_P1; m.bsel = B_P1; m.nbits = NB_COORD;
        m.comp = 2'(s); m.clear = (s == 4'd0);
        m.store = (s == 4'd2) ? SD_N1 : SD_NONE;
      end
      4'd3, 4'd4, 4'd5: begin
        m.asel = A_P2; m.bsel = B_P2; m.nbits = NB_COORD;
        m.comp = 2'(s - 4'd3); m.clear = (s == 4'd3);
        m.store = (s == 4'd5) ? SD_N2 : SD_NONE;
      end
      4'd6: begin
        m.asel = A_RAD; m.bsel = B_RAD; m.nbits = NB_COORD;
        m.clear = 1'b1; m.store = SD_RR;
      end
      4'd7, 4'd8, 4'd9: begin
        m.asel = A_D; m.bsel = B_D; m.nbits = NB_DIFF;
        m.comp = 2'(s - 4'd7); m.clear = (s == 4'd7);
        m.store = (s == 4'd9) ? SD_A : SD_NONE;
      end
      4'd10, 4'd11, 4'd12: begin
        m.asel = A_P1; m.bsel = B_D; m.nbits = NB_DIFF;
        m.comp = 2'(s - 4'd10); m.clear = (s == 4'd10);
        m.store = (s == 4'd12) ? SD_H : SD_NONE;
      end
      4'd13: begin
        m.asel = A_H; m.bsel = B_H; m.nbits = NB_WIDE; m.clear = 1'b1;
      end
      4'd14: begin
        m.asel = A_NEGA; m.bsel = B_C; m.nbits = NB_WIDE; m.store = SD_DISC;
      end
      default: m.store = SD_NONE;
    endcase
    return m;
  endfunction

  assign sop       = seg_step(step_r);
  assign examine   = !in_first && !in_last && (cnt_r == 2'd2);
  assign skip      = ((step_r == STEP_A) && sts.in1 && sts.in2) ||
                     ((step_r == STEP_H) && sts.a_zero);
  assign two_roots = sts.out1 && sts.out2 && !sts.disc_zero;
  assign cur_plus  = root_idx_r || sts.in1;
  assign cur_ok    = cur_plus ? sts.p_ok : sts.m_ok;
  assign next_ok   = two_roots && !root_idx_r && sts.p_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= '0;
      vcomp_r    <= '0;
      root_idx_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      vcomp_r    <= vcomp_nxt;
      root_idx_r <= root_idx_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    vcomp_nxt    = vcomp_r;
    root_idx_nxt = root_idx_r;
    cnt_nxt      = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          step_nxt  = '0;
          state_nxt = examine ? S_SEG_GO : S_COMMIT;
          if (in_last) begin
            cnt_nxt = 2'd0;
          end else if (in_first) begin
            cnt_nxt = 2'd1;
          end else if (cnt_r != 2'd2) begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
      S_SEG_GO:    state_nxt = skip ? S_COMMIT : S_SEG_WAIT;
      S_SEG_WAIT: begin
        if (!sts.mac_busy) begin
          if (step_r == STEP_LAST) begin
            state_nxt = S_SQRT_GO;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = S_SEG_GO;
          end
        end
      end
      S_SQRT_GO:   state_nxt = sts.disc_neg ? S_COMMIT : S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (!sts.sqrt_busy) begin
          root_idx_nxt = 1'b0;
          state_nxt    = S_ROOT_SEL;
        end
      end
      S_ROOT_SEL: begin
        if (cur_ok) begin
          state_nxt = S_DIV_GO;
        end else if (two_roots && !root_idx_r) begin
          root_idx_nxt = 1'b1;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_DIV_GO:    state_nxt = S_DIV_WAIT;
      S_DIV_WAIT:  state_nxt = sts.div_busy ? S_DIV_WAIT : S_E_GO;
      S_E_GO:      state_nxt = S_E_WAIT;
      S_E_WAIT: begin
        if (!sts.mac_busy) begin
          vcomp_nxt = 2'd0;
          state_nxt = S_V_GO;
        end
      end
      S_V_GO:      state_nxt = S_V_WAIT;
      S_V_WAIT: begin
        if (!sts.mac_busy) begin
          if (vcomp_r == 2'd2) begin
            state_nxt = S_EMIT;
          end else begin
            vcomp_nxt = vcomp_r + 2'd1;
            state_nxt = S_V_GO;
          end
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          if (two_roots && !root_idx_r) begin
            root_idx_nxt = 1'b1;
            state_nxt    = S_ROOT_SEL;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_COMMIT:    state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    cmd.op    = sop;
    cmd.store = SD_NONE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_SEG_GO:   cmd.mac_start = !skip;
      S_SEG_WAIT: cmd.store = sts.mac_busy ? SD_NONE : sop.store;
      S_SQRT_GO:  cmd.sqrt_start = !sts.disc_neg;
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.root_plus = cur_plus;
      end
      S_E_GO, S_E_WAIT: begin
        cmd.op.asel  = A_DT;
        cmd.op.bsel  = B_L;
        cmd.op.nbits = NB_FRAC;
        cmd.op.clear = 1'b1;
        cmd.mac_start = (state_r == S_E_GO);
        cmd.store     = (state_r == S_E_WAIT && !sts.mac_busy) ? SD_E : SD_NONE;
      end
      S_V_GO, S_V_WAIT: begin
        cmd.op.asel  = A_E;
        cmd.op.bsel  = B_V1;
        cmd.op.comp  = vcomp_r;
        cmd.op.nbits = NB_COORD;
        cmd.op.clear = 1'b1;
        cmd.mac_start = (state_r == S_V_GO);
        cmd.store     = (state_r == S_V_WAIT && !sts.mac_busy) ? SD_POS : SD_NONE;
      end
      S_EMIT: begin
        cmd.out_load = !sts.out_busy;
        cmd.out_last = !next_ok;
      end
      S_COMMIT:   cmd.commit = 1'b1;
      default:    ;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a waiting result");

  a_mac_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_start |=> sts.mac_busy)
    else $error("multiply-accumulate did not start");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("request accepted without leaving idle");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !cmd.commit)
    else $error("event committed twice");

endmodule

/* hdl/segment_sphere_crossing.sv */
// ----------------------------------------------------------------------------
// segment_sphere_crossing
// Crossings of trajectory segments with a sphere of configured radius.
// ----------------------------------------------------------------------------
// flow: an event that examines no segment goes from accept through the commit
//   state back to idle; an examined segment runs through the square root, plus
//   the division and the multiply steps for each crossing computed
// throughput: one request at a time, set by the bit-serial multiply-accumulate
//   unit (one multiplier bit a cycle, up to 15 operations per segment, 4 per crossing)
// reset: rst_n synchronous active low, clears previous event, event count,
//   control state and result valid; radius returns to 417529856
// ----------------------------------------------------------------------------
module segment_sphere_crossing import ssc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (lowest bit up)
  input  logic [DATA_W-1:0]  in_tdata,
  // first_event
  input  logic               in_tuser,
  // last_event
  input  logic               in_tlast,
  input  logic               in_tvalid,
  output logic               in_tready,
  // cross_time, cross_x, cross_y, cross_z, cross_vx, cross_vy, cross_vz
  output logic [DATA_W-1:0]  out_tdata,
  // last_crossing
  output logic               out_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  // detection radius, unsigned Q15.16 km
  input  logic               cfg_wr_en,
  input  logic [RAD_W-1:0]   cfg_wr_data
);

  ssc_cmd_t cmd;
  ssc_sts_t sts;

  // sequencer: counts events of a trajectory, orders the arithmetic steps,
  // picks incoming / outgoing roots and hands results to the output register
  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_first  (in_tuser),
    .in_last   (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: event registers, quadratic terms, shared multiply-accumulate,
  // square root and fraction divider, result register
  ssc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready)
  );

endmodule
